@@ sv/saar_pkg.sv @@
`default_nettype none

package saar_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 16;
  localparam int unsigned COEFF_FRAC_BITS_DEF = 14;
  localparam int unsigned COEFF_BITS          = 16;
  localparam int unsigned NUM_AXES            = 3;
  localparam int unsigned ROW_BITS            = NUM_AXES * COEFF_BITS;
  localparam int unsigned CFG_IDX_BITS        = 8;
  localparam int unsigned CFG_DATA_BITS       = ROW_BITS;
  localparam int unsigned QUEUE_DEPTH         = 2;

  typedef enum logic [2:0] {
    ORIENT_CW0       = 3'd0,
    ORIENT_CW90      = 3'd1,
    ORIENT_CW180     = 3'd2,
    ORIENT_CW270     = 3'd3,
    ORIENT_FLIP_CW0  = 3'd4,
    ORIENT_FLIP_CW90 = 3'd5,
    ORIENT_FLIP_CW180 = 3'd6,
    ORIENT_FLIP_CW270 = 3'd7
  } orient_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FINE_EN = 8'd0,
    CFG_X_ROW   = 8'd1,
    CFG_Y_ROW   = 8'd2,
    CFG_Z_ROW   = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                fine_en;
    logic [ROW_BITS-1:0] x_row;
    logic [ROW_BITS-1:0] y_row;
    logic [ROW_BITS-1:0] z_row;
  } align_cfg_t;

endpackage

`default_nettype wire

@@ sv/saar_front.sv @@
`default_nettype none

module saar_front #(
  parameter int unsigned SAMPLE_BITS = saar_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  saar_pkg::orient_e                    orientation_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_x_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_y_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_z_i,
  input  logic                                 full_i,
  output logic                                 push_o,
  output logic [3*(SAMPLE_BITS+1)-1:0]         vec_o
);
  import saar_pkg::*;

  localparam int unsigned RW = SAMPLE_BITS + 1;

  logic signed [RW-1:0] px, py, pz;
  logic signed [RW-1:0] nx, ny, nz;
  logic signed [RW-1:0] rx, ry, rz;

  assign px = RW'(in_x_i);
  assign py = RW'(in_y_i);
  assign pz = RW'(in_z_i);
  assign nx = -px;
  assign ny = -py;
  assign nz = -pz;

  always_comb begin
    unique case (orientation_i)
      ORIENT_CW90: begin
        rx = py; ry = nx; rz = pz;
      end
      ORIENT_CW180: begin
        rx = nx; ry = ny; rz = pz;
      end
      ORIENT_CW270: begin
        rx = ny; ry = px; rz = pz;
      end
      ORIENT_FLIP_CW0: begin
        rx = nx; ry = py; rz = nz;
      end
      ORIENT_FLIP_CW90: begin
        rx = py; ry = px; rz = nz;
      end
      ORIENT_FLIP_CW180: begin
        rx = px; ry = ny; rz = nz;
      end
      ORIENT_FLIP_CW270: begin
        rx = ny; ry = nx; rz = nz;
      end
      default: begin
        rx = px; ry = py; rz = pz;
      end
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign vec_o      = {rz, ry, rx};

endmodule

`default_nettype wire

@@ sv/saar_queue.sv @@
`default_nettype none

module saar_queue #(
  parameter int unsigned WIDTH = 51,
  parameter int unsigned DEPTH = saar_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import saar_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("count did not advance on push");

endmodule

`default_nettype wire

@@ sv/saar_back.sv @@
`default_nettype none

module saar_back #(
  parameter int unsigned SAMPLE_BITS     = saar_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_FRAC_BITS = saar_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  saar_pkg::align_cfg_t              cfg_i,
  input  logic                              valid_i,
  input  logic [3*(SAMPLE_BITS+1)-1:0]      vec_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS+1:0]     out_x_o,
  output logic signed [SAMPLE_BITS+1:0]     out_y_o,
  output logic signed [SAMPLE_BITS+1:0]     out_z_o
);
  import saar_pkg::*;

  localparam int unsigned RW    = SAMPLE_BITS + 1;
  localparam int unsigned PW    = COEFF_BITS + RW;
  localparam int unsigned AW    = PW + 2;
  localparam int unsigned OW    = SAMPLE_BITS + 2;
  localparam int unsigned F     = COEFF_FRAC_BITS;
  localparam int unsigned SUMW  = AW + F;
  localparam int unsigned QW    = AW;
  localparam int unsigned QRW   = QW + 1;
  localparam logic [F-1:0] HALF = {1'b1, {(F-1){1'b0}}};
  localparam logic signed [QRW-1:0] SAT_HI = {{(QRW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [QRW-1:0] SAT_LO = ~SAT_HI;

  logic                  adv;
  logic [ROW_BITS-1:0]   rows [NUM_AXES];
  logic signed [RW-1:0]  r_in [NUM_AXES];

  logic                  s1_valid_q;
  logic signed [PW-1:0]  s1_prod_q [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0]  s1_prod_d [NUM_AXES][NUM_AXES];
  logic signed [RW-1:0]  s1_r_q [NUM_AXES];

  logic                  s2_valid_q;
  logic signed [AW-1:0]  s2_acc_q [NUM_AXES];
  logic signed [AW-1:0]  s2_acc_d [NUM_AXES];
  logic signed [RW-1:0]  s2_r_q [NUM_AXES];

  logic                  out_valid_q;
  logic signed [OW-1:0]  out_q [NUM_AXES];
  logic signed [OW-1:0]  out_d [NUM_AXES];

  logic signed [SUMW-1:0] ext   [NUM_AXES];
  logic signed [QW-1:0]   quo   [NUM_AXES];
  logic [F-1:0]           rem   [NUM_AXES];
  logic                   up    [NUM_AXES];
  logic signed [QRW-1:0]  qr    [NUM_AXES];
  logic signed [QRW-1:0]  sat   [NUM_AXES];

  assign rows[0] = cfg_i.x_row;
  assign rows[1] = cfg_i.y_row;
  assign rows[2] = cfg_i.z_row;

  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && valid_i;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      r_in[a] = vec_i[a*RW +: RW];
    end
    for (int o = 0; o < NUM_AXES; o++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        s1_prod_d[o][a] = PW'($signed(rows[o][a*COEFF_BITS +: COEFF_BITS])) * PW'(r_in[a]);
      end
    end
  end

  always_comb begin
    for (int o = 0; o < NUM_AXES; o++) begin
      s2_acc_d[o] = AW'(s1_prod_q[o][0]) + AW'(s1_prod_q[o][1]) + AW'(s1_prod_q[o][2]);
    end
  end

  always_comb begin
    for (int o = 0; o < NUM_AXES; o++) begin
      ext[o] = SUMW'(s2_acc_q[o]);
      quo[o] = ext[o][SUMW-1:F];
      rem[o] = ext[o][F-1:0];
      up[o]  = (rem[o] > HALF) || ((rem[o] == HALF) && quo[o][0]);
      qr[o]  = QRW'(quo[o]) + QRW'({1'b0, up[o]});
      if (qr[o] > SAT_HI) begin
        sat[o] = SAT_HI;
      end else if (qr[o] < SAT_LO) begin
        sat[o] = SAT_LO;
      end else begin
        sat[o] = qr[o];
      end
      out_d[o] = cfg_i.fine_en ? sat[o][OW-1:0] : OW'(s2_r_q[o]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q <= s1_prod_d;
      s1_r_q    <= r_in;
      s2_acc_q  <= s2_acc_d;
      s2_r_q    <= s1_r_q;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(s1_valid_q) && $stable(s2_valid_q)))
    else $error("pipeline moved while output stalled");

  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_q == $past(s2_valid_q)))
    else $error("output valid lost its stage");

  a_bypass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !cfg_i.fine_en) |->
      ((out_q[0][OW-1] == out_q[0][OW-2]) && (out_q[1][OW-1] == out_q[1][OW-2]) &&
       (out_q[2][OW-1] == out_q[2][OW-2])))
    else $error("bypass value exceeds remap range");

endmodule

`default_nettype wire

@@ sv/sensor_axis_align_rotate.sv @@
`default_nettype none

// Three-axis sensor alignment. Each sample is remapped by its orientation code
// (four clockwise turns, each with or without a flip) and, with fine alignment
// enabled, multiplied by a 3x3 matrix of signed coefficients with
// COEFF_FRAC_BITS fraction bits, rounded to nearest even and saturated to
// SAMPLE_BITS+2 bits. One sample is accepted every clock while the queue is not
// full; each result passes through the queue, then the product stage with its
// nine parallel multipliers, the sum stage and the round/saturate output
// register. Coefficients are loaded through the config channel and
// reset to the identity with fine alignment off; write them only while idle.
module sensor_axis_align_rotate #(
  parameter int unsigned SAMPLE_BITS     = saar_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEFF_FRAC_BITS = saar_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [saar_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [saar_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  saar_pkg::orient_e                      orientation_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_x_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_y_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [SAMPLE_BITS+1:0]          out_x_o,
  output logic signed [SAMPLE_BITS+1:0]          out_y_o,
  output logic signed [SAMPLE_BITS+1:0]          out_z_o
);
  import saar_pkg::*;

  localparam int unsigned VW = 3 * (SAMPLE_BITS + 1);
  localparam logic [ROW_BITS-1:0] X_ROW_RST = ROW_BITS'(1) << COEFF_FRAC_BITS;
  localparam logic [ROW_BITS-1:0] Y_ROW_RST = ROW_BITS'(1) << (COEFF_FRAC_BITS + COEFF_BITS);
  localparam logic [ROW_BITS-1:0] Z_ROW_RST =
    ROW_BITS'(1) << (COEFF_FRAC_BITS + 2 * COEFF_BITS);

  align_cfg_t    cfg_q, cfg_d;
  logic          push, full, q_valid, pop;
  logic [VW-1:0] push_vec, pop_vec;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FINE_EN: cfg_d.fine_en = cfg_data_i[0];
        CFG_X_ROW:   cfg_d.x_row   = cfg_data_i[ROW_BITS-1:0];
        CFG_Y_ROW:   cfg_d.y_row   = cfg_data_i[ROW_BITS-1:0];
        CFG_Z_ROW:   cfg_d.z_row   = cfg_data_i[ROW_BITS-1:0];
        default:     cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fine_en <= 1'b0;
      cfg_q.x_row   <= X_ROW_RST;
      cfg_q.y_row   <= Y_ROW_RST;
      cfg_q.z_row   <= Z_ROW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  saar_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .orientation_i (orientation_i),
    .in_x_i        (in_x_i),
    .in_y_i        (in_y_i),
    .in_z_i        (in_z_i),
    .full_i        (full),
    .push_o        (push),
    .vec_o         (push_vec)
  );

  saar_queue #(
    .WIDTH (VW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_vec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_vec)
  );

  saar_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (q_valid),
    .vec_i       (pop_vec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

endmodule

`default_nettype wire
